// ----- sv/rpg_pkg.sv -----
// Shared constants, types and the sequencer state encoding for the permutation generator.
package rpg_pkg;

  // Field widths of the stream and configuration payloads
  localparam int WORD_W       = 32;
  localparam int VALUE_W      = 8;
  localparam int SIZE_W       = 9;

  // Default list depth and reset value of the size register
  localparam int MAX_SIZE_DEF = 256;
  localparam int SIZE_RESET   = 256;

  // Cells per first-level OR group of the extraction tree
  localparam int GRP_SIZE     = 16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEL,
    ST_GRP,
    ST_FIN
  } state_t;

  // Command broadcast to every list cell
  typedef struct packed {
    logic restart;  // reload identity value
    logic shift;    // take neighbor value if at or above pick
    logic tap;      // capture own value if at pick, else zero
  } cell_cmd_t;

endpackage

// ----- sv/rpg_cell.sv -----
// One list cell: holds one remaining value, shifts down from its upper neighbor.
module rpg_cell #(
  parameter int VW  = 8,
  parameter int LW  = 9,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rpg_pkg::cell_cmd_t cmd,
  input  logic [LW-1:0]     pick,
  input  logic [VW-1:0]     nbr_val,
  output logic [VW-1:0]     val,
  output logic [VW-1:0]     tap
);

  logic [VW-1:0] val_r;
  logic [VW-1:0] tap_r;
  logic          hit;
  logic          above;

  assign hit   = (pick == LW'(IDX));
  assign above = (LW'(IDX) >= pick);

  // List entry: identity on reset or restart, else close the gap
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      val_r <= VW'(IDX);
    end else if (cmd.shift && above) begin
      val_r <= nbr_val;
    end
  end

  // Tap: masked copy of the entry for the OR tree
  always_ff @(posedge clk) begin
    if (cmd.tap) begin
      tap_r <= hit ? val_r : '0;
    end
  end

  assign val = val_r;
  assign tap = tap_r;

endmodule

// ----- sv/rpg_mod_unit.sv -----
// Serial restoring remainder unit: one dividend bit per cycle.
module rpg_mod_unit #(
  parameter int LW = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rpg_pkg::WORD_W-1:0] word,
  input  logic [LW-1:0]              divisor,
  output logic                       busy,
  output logic [LW-1:0]              rem
);

  localparam int CNT_W = $clog2(rpg_pkg::WORD_W);

  logic                       busy_r, busy_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [rpg_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [LW-1:0]              rem_r, rem_nxt;
  logic [LW-1:0]              div_r, div_nxt;
  logic [LW:0]                trial;
  logic [LW:0]                diff;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem_r, word_r[rpg_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    word_nxt = word_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      word_nxt = word;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      word_nxt = {word_r[rpg_pkg::WORD_W-2:0], 1'b0};
      rem_nxt  = (trial >= {1'b0, div_r}) ? diff[LW-1:0] : trial[LW-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == {CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ----- sv/random_permutation_generator.sv -----
// A request runs through the serial remainder (each dividend bit in turn, then the done
// check), then shift, the grouped OR stage and the result load; the last step waits
// while the result register is still full.
// One request in flight: the next one is taken once the sequencer is back in idle after the
// result loads; the result register lets a new request enter while a result waits.
// Reset (rst_n, synchronous, active low): size 256, list to identity, count zero.
module random_permutation_generator #(
  parameter int MAX_SIZE = rpg_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rpg_pkg::WORD_W-1:0]  in_tdata,   // [31:0] random_word
  // Result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rpg_pkg::VALUE_W-1:0] out_tdata,  // [7:0] perm_value
  output logic                        out_tlast,  // last_of_perm
  // Size register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rpg_pkg::SIZE_W-1:0]  cfg_data    // [8:0] perm_size
);

  localparam int VW = $clog2(MAX_SIZE);
  localparam int LW = $clog2(MAX_SIZE + 1);
  localparam int CW = (LW > rpg_pkg::SIZE_W) ? LW : rpg_pkg::SIZE_W;
  localparam int GS = rpg_pkg::GRP_SIZE;
  localparam int NG = (MAX_SIZE + GS - 1) / GS;

  rpg_pkg::state_t           state_r, state_nxt;
  logic [rpg_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [LW-1:0]             pos_r, pos_nxt;
  logic [LW-1:0]             left_r, left_nxt;
  logic                      last_r, last_nxt;
  logic                      outv_r, outv_nxt;
  logic [VW-1:0]             outd_r, outd_nxt;
  logic                      outl_r, outl_nxt;
  logic [LW-1:0]             n_eff;
  logic [CW-1:0]             size_ext;
  rpg_pkg::cell_cmd_t        cmd;
  logic                      div_start;
  logic                      div_busy;
  logic [LW-1:0]             pick;
  logic [VW-1:0]             cell_val [MAX_SIZE];
  logic [VW-1:0]             cell_tap [MAX_SIZE];
  logic [VW-1:0]             grp_r [NG];
  logic [VW-1:0]             grp_nxt [NG];
  logic [VW-1:0]             final_or;
  logic                      in_acc;
  logic                      restart_now;

  // Effective size: zero counts as one, clamp to list depth
  assign size_ext = CW'(size_r);
  always_comb begin
    if (size_ext == '0) begin
      n_eff = LW'(1);
    end else if (size_ext > CW'(MAX_SIZE)) begin
      n_eff = LW'(MAX_SIZE);
    end else begin
      n_eff = size_ext[LW-1:0];
    end
  end

  // Size writes only in idle and ahead of a request in the same cycle
  assign cfg_ready = (state_r == rpg_pkg::ST_IDLE);
  assign in_tready = (state_r == rpg_pkg::ST_IDLE) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign restart_now = (pos_r >= n_eff);

  // Remainder unit: random word mod values left
  rpg_mod_unit #(.LW(LW)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .word    (in_tdata),
    .divisor (left_nxt),
    .busy    (div_busy),
    .rem     (pick)
  );

  // Row of list cells, each fed by its upper neighbor, the top cell by itself
  for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
    logic [VW-1:0] nbr;
    if (i == MAX_SIZE - 1) begin : g_top
      assign nbr = cell_val[i];
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    rpg_cell #(.VW(VW), .LW(LW), .IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .pick    (pick),
      .nbr_val (nbr),
      .val     (cell_val[i]),
      .tap     (cell_tap[i])
    );
  end

  // First tree level: OR of each group of taps
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < MAX_SIZE) begin
          grp_nxt[g] = grp_nxt[g] | cell_tap[g*GS+k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rpg_pkg::ST_GRP) begin
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Second tree level: OR across groups
  always_comb begin
    final_or = '0;
    for (int g = 0; g < NG; g++) begin
      final_or = final_or | grp_r[g];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    last_nxt  = last_r;
    outv_nxt  = outv_r;
    outd_nxt  = outd_r;
    outl_nxt  = outl_r;
    cmd       = '0;
    div_start = 1'b0;

    if (outv_r && out_tready) begin
      outv_nxt = 1'b0;
    end

    unique case (state_r)
      rpg_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          size_nxt    = cfg_data;
          cmd.restart = 1'b1;
          pos_nxt     = '0;
        end else if (in_acc) begin
          // Guard: counter at or past size restarts the list first
          if (restart_now) begin
            cmd.restart = 1'b1;
            pos_nxt     = '0;
            left_nxt    = n_eff;
          end else begin
            left_nxt    = n_eff - pos_r;
          end
          div_start = 1'b1;
          state_nxt = rpg_pkg::ST_DIV;
        end
      end
      rpg_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = rpg_pkg::ST_SEL;
        end
      end
      rpg_pkg::ST_SEL: begin
        cmd.tap   = 1'b1;
        cmd.shift = 1'b1;
        pos_nxt   = pos_r + 1'b1;
        last_nxt  = ((pos_r + 1'b1) >= n_eff);
        state_nxt = rpg_pkg::ST_GRP;
      end
      rpg_pkg::ST_GRP: begin
        if (last_r) begin
          cmd.restart = 1'b1;
          pos_nxt     = '0;
        end
        state_nxt = rpg_pkg::ST_FIN;
      end
      rpg_pkg::ST_FIN: begin
        if (!outv_r || out_tready) begin
          outv_nxt  = 1'b1;
          outd_nxt  = final_or;
          outl_nxt  = last_r;
          state_nxt = rpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpg_pkg::ST_IDLE;
      size_r  <= rpg_pkg::SIZE_W'(rpg_pkg::SIZE_RESET);
      pos_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      pos_r   <= pos_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    last_r <= last_nxt;
    outd_r <= outd_nxt;
    outl_r <= outl_nxt;
  end

  // Result port: low bits of the drawn value
  assign out_tvalid = outv_r;
  assign out_tdata  = rpg_pkg::VALUE_W'(outd_r);
  assign out_tlast  = outl_r;

endmodule
